### design/assert_macros.svh
// Assertion helpers used by the top-level hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define SBH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define SBH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sbh_pkg.sv
package sbh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  // first pad byte and the first fill count that leaves no room for the length
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_LIMIT = 6'd56;

  typedef enum logic [1:0] {
    BLK_DATA  = 2'd0,  // plain message block
    BLK_FIRST = 2'd1,  // last data bytes, 0x80, zeros, length if it fits
    BLK_EXTRA = 2'd2   // zeros and the length only
  } blk_kind_t;

  typedef struct packed {
    blk_kind_t   kind;
    logic [5:0]  n;     // bytes pending at finish
    logic [63:0] bits;  // message length in bits
  } pad_ctrl_t;

  typedef struct packed {
    logic       load;     // working vars <= chaining value
    logic       step;     // one compression round
    logic       fold;     // chaining value += working vars
    logic       restart;  // chaining value <= initial hash
    logic [5:0] rnd;
  } rnd_ctrl_t;

endpackage

### design/sbh_buffer.sv
module sbh_buffer (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [5:0]        wr_addr,
  input  logic [7:0]        wr_byte,
  input  logic [3:0]        rd_addr,
  input  sbh_pkg::pad_ctrl_t pad,
  output sbh_pkg::word_t    word_out
);
  import sbh_pkg::*;

  // 16 words, big-endian bytes: byte 0 of a word sits in lane 3
  logic [3:0][7:0] mem [16];
  logic [3:0][7:0] rd_q;
  logic [3:0]      ra_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][2'd3 - wr_addr[1:0]] <= wr_byte;
    end
    rd_q <= mem[rd_addr];
    ra_q <= rd_addr;
  end

  // padding applied on the read side, so the memory never needs clearing
  always_comb begin
    logic [5:0] p;
    logic       use_len;
    use_len  = (pad.kind == BLK_EXTRA) || ((pad.kind == BLK_FIRST) && (pad.n < LEN_LIMIT));
    word_out = rd_q;
    for (int k = 0; k < 4; k++) begin
      p = {ra_q, 2'(k)};
      unique case (pad.kind)
        BLK_DATA:  word_out[31 - 8*k -: 8] = rd_q[3 - k];
        BLK_FIRST: begin
          if (p < pad.n) begin
            word_out[31 - 8*k -: 8] = rd_q[3 - k];
          end else if (p == pad.n) begin
            word_out[31 - 8*k -: 8] = PAD_BYTE;
          end else begin
            word_out[31 - 8*k -: 8] = 8'h00;
          end
        end
        default:   word_out[31 - 8*k -: 8] = 8'h00;
      endcase
    end
    if (use_len && ra_q == 4'd14) begin
      word_out = pad.bits[63:32];
    end else if (use_len && ra_q == 4'd15) begin
      word_out = pad.bits[31:0];
    end
  end

endmodule

### design/sbh_round.sv
module sbh_round (
  input  logic               clk,
  input  logic               rst,
  input  sbh_pkg::rnd_ctrl_t ctrl,
  input  sbh_pkg::word_t     w_in,
  output sbh_pkg::hash_t     cv
);
  import sbh_pkg::*;

  localparam hash_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_s0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_s1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_s0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_s1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  hash_t           wv;   // a..h at indexes 0..7
  logic [15:0][31:0] win;  // win[15] is the newest schedule word
  word_t           w_next;  // schedule word of the following round
  word_t           w_pre;   // schedule word of this round, from rounds 16 on
  word_t           w_cur;
  word_t           t1;
  word_t           t2;
  word_t           ch;
  word_t           maj;

  // one round ahead: W[i+1] from W[i-1], W[i-6], W[i-14], W[i-15]
  assign w_next = small_s1(win[15]) + win[10] + small_s0(win[2]) + win[1];
  assign w_cur  = (ctrl.rnd[5:4] == 2'b00) ? w_in : w_pre;
  assign ch     = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj    = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1     = wv[7] + big_s1(wv[4]) + ch + K_TAB[ctrl.rnd] + w_cur;
  assign t2     = big_s0(wv[0]) + maj;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      wv <= cv;
    end else if (ctrl.step) begin
      wv    <= {wv[6], wv[5], wv[4], wv[3] + t1, wv[2], wv[1], wv[0], t1 + t2};
      win   <= {w_cur, win[15:1]};
      w_pre <= w_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      cv <= IV;
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= cv[i] + wv[i];
      end
    end
  end

endmodule

### design/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream. Each input word either absorbs one message byte
// (tuser low) or finishes the message (tuser high). Input is taken only while
// the hasher is idle; the byte that completes a 64-byte block starts a
// compression on the single round unit, one round per cycle, and the input
// stays not ready for the whole compression (a load of the working variables,
// 64 rounds, a fold into the chaining value). A finish pads the message on the
// fly as the block is read back (0x80, zeros, 64-bit big-endian bit length) and
// runs one compression, or two when 56 or more bytes were pending, then offers
// the digest as eight output words, most significant first, the eighth with
// tlast. After the last digest word is taken the hasher is back at the
// initial hash values and a new message may start. The bit length wraps
// modulo 2^64. No output word is produced for an absorb.
`include "assert_macros.svh"

module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] mode: 0 absorb, 1 finish
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        m_tlast    // is_last
);
  import sbh_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t      state;
  blk_kind_t   kind;
  logic [5:0]  fill;     // bytes pending in the block buffer
  logic [54:0] blocks;   // full blocks absorbed; their bit length is blocks * 512
  logic [5:0]  pad_n;    // fill count captured at finish
  logic [5:0]  rnd;
  logic [2:0]  out_idx;

  logic        s_acc;
  logic        m_acc;
  pad_ctrl_t   pad;
  rnd_ctrl_t   rctl;
  word_t       w_word;
  hash_t       cv;
  logic [3:0]  rd_addr;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  assign m_tdata  = {5'b00000, out_idx, cv[out_idx]};
  assign m_tlast  = (out_idx == 3'd7);

  // bit length = blocks*512 + pad_n*8, no adder needed
  assign pad.kind = kind;
  assign pad.n    = pad_n;
  assign pad.bits = {blocks, pad_n, 3'b000};

  // prefetch the schedule word of the next round through the buffer's read register
  assign rd_addr = (state == ST_ROUND) ? (rnd[3:0] + 4'd1) : 4'd0;

  assign rctl.load    = (state == ST_LOAD);
  assign rctl.step    = (state == ST_ROUND);
  assign rctl.fold    = (state == ST_FOLD);
  assign rctl.restart = m_acc && m_tlast;
  assign rctl.rnd     = rnd;

  sbh_buffer u_buffer (
    .clk      (clk),
    .wr_en    (s_acc && !s_tuser),
    .wr_addr  (fill),
    .wr_byte  (s_tdata),
    .rd_addr  (rd_addr),
    .pad      (pad),
    .word_out (w_word)
  );

  sbh_round u_round (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rctl),
    .w_in (w_word),
    .cv   (cv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      kind    <= BLK_DATA;
      fill    <= '0;
      blocks  <= '0;
      pad_n   <= '0;
      rnd     <= '0;
      out_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_tuser) begin
              pad_n <= fill;
              kind  <= BLK_FIRST;
              state <= ST_LOAD;
            end else begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                kind   <= BLK_DATA;
                blocks <= blocks + 55'd1;
                state  <= ST_LOAD;
              end
            end
          end
        end
        ST_LOAD: begin
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          out_idx <= '0;
          unique case (kind)
            BLK_DATA: state <= ST_IDLE;
            BLK_FIRST: begin
              // no room for the length: one more block of zeros and length
              if (pad_n >= LEN_LIMIT) begin
                kind  <= BLK_EXTRA;
                state <= ST_LOAD;
              end else begin
                state <= ST_EMIT;
              end
            end
            default: state <= ST_EMIT;
          endcase
        end
        ST_EMIT: begin
          if (m_acc) begin
            out_idx <= out_idx + 3'd1;
            if (m_tlast) begin
              fill   <= '0;
              blocks <= '0;
              state  <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SBH_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input ready while digest pending")
  `SBH_ASSERT_NEXT(a_block_starts, s_acc && !s_tuser && fill == 6'd63, state == ST_LOAD, "full block did not start compression")
  `SBH_ASSERT_NEXT(a_restart, m_acc && m_tlast, state == ST_IDLE && fill == 6'd0 && blocks == 55'd0, "hasher not cleared after last digest word")
  `SBH_ASSERT_NEXT(a_load_round, state == ST_LOAD, state == ST_ROUND && rnd == 6'd0, "round sequence did not start at zero")

endmodule
